[hw/rtl/masked_patch_ssd_energy_core_assert.svh]
// Assertion macros for the patch energy core.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef MASKED_PATCH_SSD_ENERGY_CORE_ASSERT_SVH
`define MASKED_PATCH_SSD_ENERGY_CORE_ASSERT_SVH

`ifndef NO_ASSERTIONS

// The consequent holds in the same cycle as the antecedent.
`define MPSE_ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

// The consequent holds in the cycle after the antecedent.
`define MPSE_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define MPSE_ASSERT_SAME(lbl, ante, cons)
`define MPSE_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

[hw/rtl/mpse_pkg.sv]
package mpse_pkg;

	// Signed coordinate and span type used during rectangle clamping.
	localparam int CRD_W = 16;
	typedef logic signed [CRD_W-1:0] crd_t;

	typedef struct packed {
		crd_t pa;
		crd_t pb;
		crd_t size;
	} span_t;

	// Clamping runs as four dependent steps, one per cycle.
	localparam logic [1:0] CLAMP_NEG_A = 2'd0;
	localparam logic [1:0] CLAMP_NEG_B = 2'd1;
	localparam logic [1:0] CLAMP_END_A = 2'd2;
	localparam logic [1:0] CLAMP_END_B = 2'd3;

	// Configuration register indexes.
	localparam logic [2:0] CFG_A_LEFT       = 3'd0;
	localparam logic [2:0] CFG_A_TOP        = 3'd1;
	localparam logic [2:0] CFG_PATCH_WIDTH  = 3'd2;
	localparam logic [2:0] CFG_PATCH_HEIGHT = 3'd3;
	localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd4;
	localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd5;
	localparam logic [2:0] CFG_A_MASKED     = 3'd6;

	// Input item actions.
	localparam logic ACT_LOAD    = 1'b0;
	localparam logic ACT_COMPUTE = 1'b1;

	// Pixel word: mask bit on top of blue, green, red.
	localparam int PIX_W = 25;

	localparam int ENERGY_W = 34;
	localparam int ACC_W    = 36;
	localparam logic [ACC_W-1:0] ENERGY_CEIL = ACC_W'((64'd1 << ENERGY_W) - 64'd1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CLAMP,
		ST_CHECK,
		ST_BASE_A,
		ST_BASE_B,
		ST_WALK,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// One step of clamping a pair of corners and their shared size to [0, limit).
	function automatic span_t clamp_step(logic [1:0] step, span_t s, crd_t limit);
		span_t r;
		crd_t d;
		r = s;
		d = '0;
		case (step)
			CLAMP_NEG_A: begin
				if (s.pa < 0) begin
					d = -s.pa;
					r.pa = '0;
					r.pb = s.pb + d;
					r.size = s.size - d;
				end
			end
			CLAMP_NEG_B: begin
				if (s.pb < 0) begin
					d = -s.pb;
					r.pa = s.pa + d;
					r.pb = '0;
					r.size = s.size - d;
				end
			end
			CLAMP_END_A: begin
				if (s.pa + s.size > limit) r.size = limit - s.pa;
			end
			CLAMP_END_B: begin
				if (s.pb + s.size > limit) r.size = limit - s.pb;
			end
			default: r = s;
		endcase
		return r;
	endfunction

endpackage

[hw/rtl/mpse_pix_mem.sv]
module mpse_pix_mem #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16
) (
	input  logic                        clk,
	input  logic                        we,
	input  logic [AW-1:0]               waddr,
	input  logic [mpse_pkg::PIX_W-1:0]  wdata,
	input  logic                        re,
	input  logic [AW-1:0]               raddr_a,
	input  logic [AW-1:0]               raddr_b,
	output logic [mpse_pkg::PIX_W-1:0]  rdata_a,
	output logic [mpse_pkg::PIX_W-1:0]  rdata_b
);

	logic [mpse_pkg::PIX_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

[hw/rtl/masked_patch_ssd_energy_core.sv]
// Masked sum-of-squared-differences patch matcher over a stored RGB24 image.
//
// Input channel (in_valid / in_stall): an item with action load writes one
// pixel and its known bit into the image memory and gives no result; loads
// outside MAX_WIDTH by MAX_HEIGHT are dropped. An item with action compute
// names the corner of candidate patch B and gives one energy.
// Output channel (out_valid / out_stall): one 34-bit energy per compute item.
// Configuration (cfg_we, cfg_idx, cfg_data) sets patch A's corner, the patch
// size, the image size and the masking mode; write it only while idle.
//
// A compute runs through the clamp steps, a check, the base-address states
// ST_BASE_A and ST_BASE_B, a walk over the w * h pixel pairs of the clamped
// patch at one pair per cycle, as the single pixel-pair path fed from the two
// read ports of the image memory allows, a drain and a finish state. The
// result becomes valid in the same cycle as the next transfer can be taken. An
// empty clamped region returns zero. in_stall is high for the whole compute.
// The result sits in an output register, so a new transfer is accepted while
// it waits; a finished compute holds in its last state until that register is
// free. Reset sets the control state and the configuration registers to
// defaults; the image memory is not cleared and must be loaded before use.
module masked_patch_ssd_energy_core #(
	parameter int MAX_WIDTH  = 256,
	parameter int MAX_HEIGHT = 256
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic                           action,
	input  logic [7:0]                     pix_x,
	input  logic [7:0]                     pix_y,
	input  logic [7:0]                     red,
	input  logic [7:0]                     green,
	input  logic [7:0]                     blue,
	input  logic                           known,
	input  logic signed [8:0]              b_left,
	input  logic signed [8:0]              b_top,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [mpse_pkg::ENERGY_W-1:0]  energy,
	input  logic                           cfg_we,
	input  logic [2:0]                     cfg_idx,
	input  logic [8:0]                     cfg_data
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = $clog2(DEPTH);

	// Configuration registers.
	logic signed [8:0] a_left_q, a_top_q;
	logic [8:0]        patch_width_q, patch_height_q, image_width_q, image_height_q;
	logic              a_masked_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_left_q       <= '0;
			a_top_q        <= '0;
			patch_width_q  <= 9'd8;
			patch_height_q <= 9'd8;
			image_width_q  <= 9'd256;
			image_height_q <= 9'd256;
			a_masked_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_idx)
				mpse_pkg::CFG_A_LEFT:       a_left_q       <= cfg_data;
				mpse_pkg::CFG_A_TOP:        a_top_q        <= cfg_data;
				mpse_pkg::CFG_PATCH_WIDTH:  patch_width_q  <= cfg_data;
				mpse_pkg::CFG_PATCH_HEIGHT: patch_height_q <= cfg_data;
				mpse_pkg::CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data;
				mpse_pkg::CFG_IMAGE_HEIGHT: image_height_q <= cfg_data;
				mpse_pkg::CFG_A_MASKED:     a_masked_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Image size saturated to the memory's extent.
	mpse_pkg::crd_t lim_x, lim_y;
	assign lim_x = (32'(image_width_q) > MAX_WIDTH) ?
		mpse_pkg::crd_t'(MAX_WIDTH) : mpse_pkg::crd_t'(image_width_q);
	assign lim_y = (32'(image_height_q) > MAX_HEIGHT) ?
		mpse_pkg::crd_t'(MAX_HEIGHT) : mpse_pkg::crd_t'(image_height_q);

	// Control.
	mpse_pkg::state_t state_q, state_d;
	logic [1:0]       step_q;
	logic             in_xfer, load_xfer, comp_xfer;
	logic             issue, slot_free, finish;
	logic             last_col, last_row;
	logic             v_s1_q, v_s2_q, out_valid_q;

	// Datapath registers.
	mpse_pkg::span_t              xs_q, ys_q;
	logic [8:0]                   w_q, h_q, x_q, y_q;
	logic [AW-1:0]                row_step_q, a_addr_q, b_addr_q;
	logic                         use_s2;
	logic [15:0]                  sq_r_s2, sq_g_s2, sq_b_s2;
	logic [mpse_pkg::ACC_W-1:0]   acc_q;
	logic [mpse_pkg::ENERGY_W-1:0] energy_q;

	assign in_xfer   = in_valid && !in_stall;
	assign load_xfer = in_xfer && (action == mpse_pkg::ACT_LOAD);
	assign comp_xfer = in_xfer && (action == mpse_pkg::ACT_COMPUTE);
	assign slot_free = !out_valid_q || !out_stall;
	assign last_col  = (x_q == w_q - 9'd1);
	assign last_row  = (y_q == h_q - 9'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mpse_pkg::ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d  = state_q;
		in_stall = 1'b1;
		issue    = 1'b0;
		finish   = 1'b0;
		case (state_q)
			mpse_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				if (comp_xfer) state_d = mpse_pkg::ST_CLAMP;
			end
			mpse_pkg::ST_CLAMP: begin
				if (step_q == mpse_pkg::CLAMP_END_B) state_d = mpse_pkg::ST_CHECK;
			end
			mpse_pkg::ST_CHECK: begin
				if (xs_q.size <= 0 || ys_q.size <= 0) state_d = mpse_pkg::ST_FINISH;
				else                                  state_d = mpse_pkg::ST_BASE_A;
			end
			mpse_pkg::ST_BASE_A: state_d = mpse_pkg::ST_BASE_B;
			mpse_pkg::ST_BASE_B: state_d = mpse_pkg::ST_WALK;
			mpse_pkg::ST_WALK: begin
				issue = 1'b1;
				if (last_col && last_row) state_d = mpse_pkg::ST_DRAIN;
			end
			mpse_pkg::ST_DRAIN: begin
				if (!v_s1_q && !v_s2_q) state_d = mpse_pkg::ST_FINISH;
			end
			mpse_pkg::ST_FINISH: begin
				if (slot_free) begin
					finish  = 1'b1;
					state_d = mpse_pkg::ST_IDLE;
				end
			end
			default: state_d = mpse_pkg::ST_IDLE;
		endcase
	end

	// Clamp step counter, pipeline valid bits and the output valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			v_s1_q      <= 1'b0;
			v_s2_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (comp_xfer)                            step_q <= mpse_pkg::CLAMP_NEG_A;
			else if (state_q == mpse_pkg::ST_CLAMP)   step_q <= step_q + 2'd1;
			v_s1_q <= issue;
			v_s2_q <= v_s1_q;
			if (finish)          out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	// Shared row-base multiplier: patch A's start in ST_BASE_A, patch B's in ST_BASE_B.
	mpse_pkg::crd_t mul_row, mul_col;
	logic [AW-1:0]  base_addr;
	assign mul_row   = (state_q == mpse_pkg::ST_BASE_A) ? ys_q.pa : ys_q.pb;
	assign mul_col   = (state_q == mpse_pkg::ST_BASE_A) ? xs_q.pa : xs_q.pb;
	assign base_addr = AW'(AW'(mul_row) * AW'(MAX_WIDTH)) + AW'(mul_col);

	// Load and clamp the two rectangles, set up the base addresses and walk over the clamped patch.
	always_ff @(posedge clk) begin
		if (comp_xfer) begin
			xs_q.pa   <= mpse_pkg::crd_t'(a_left_q);
			xs_q.pb   <= mpse_pkg::crd_t'(b_left);
			xs_q.size <= mpse_pkg::crd_t'(patch_width_q);
			ys_q.pa   <= mpse_pkg::crd_t'(a_top_q);
			ys_q.pb   <= mpse_pkg::crd_t'(b_top);
			ys_q.size <= mpse_pkg::crd_t'(patch_height_q);
		end else if (state_q == mpse_pkg::ST_CLAMP) begin
			xs_q <= mpse_pkg::clamp_step(step_q, xs_q, lim_x);
			ys_q <= mpse_pkg::clamp_step(step_q, ys_q, lim_y);
		end

		if (state_q == mpse_pkg::ST_CHECK) begin
			w_q        <= xs_q.size[8:0];
			h_q        <= ys_q.size[8:0];
			row_step_q <= AW'(MAX_WIDTH) - AW'(xs_q.size) + AW'(1);
			x_q        <= '0;
			y_q        <= '0;
		end

		if (state_q == mpse_pkg::ST_BASE_A) a_addr_q <= base_addr;
		if (state_q == mpse_pkg::ST_BASE_B) b_addr_q <= base_addr;

		if (issue) begin
			if (last_col) begin
				x_q      <= '0;
				y_q      <= y_q + 9'd1;
				a_addr_q <= a_addr_q + row_step_q;
				b_addr_q <= b_addr_q + row_step_q;
			end else begin
				x_q      <= x_q + 9'd1;
				a_addr_q <= a_addr_q + AW'(1);
				b_addr_q <= b_addr_q + AW'(1);
			end
		end
	end

	// Image and mask memory.
	logic                          mem_we;
	logic [AW-1:0]                 mem_waddr;
	logic [mpse_pkg::PIX_W-1:0]    rd_a, rd_b;

	assign mem_we    = load_xfer && (32'(pix_x) < MAX_WIDTH) && (32'(pix_y) < MAX_HEIGHT);
	assign mem_waddr = AW'(AW'(pix_y) * AW'(MAX_WIDTH)) + AW'(pix_x);

	mpse_pix_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_pix_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   ({known, blue, green, red}),
		.re      (issue),
		.raddr_a (a_addr_q),
		.raddr_b (b_addr_q),
		.rdata_a (rd_a),
		.rdata_b (rd_b)
	);

	// Stage 2: per-channel absolute differences and squares.
	logic [7:0] ad_r, ad_g, ad_b;
	assign ad_r = (rd_a[7:0]   > rd_b[7:0])   ? rd_a[7:0]   - rd_b[7:0]   : rd_b[7:0]   - rd_a[7:0];
	assign ad_g = (rd_a[15:8]  > rd_b[15:8])  ? rd_a[15:8]  - rd_b[15:8]  : rd_b[15:8]  - rd_a[15:8];
	assign ad_b = (rd_a[23:16] > rd_b[23:16]) ? rd_a[23:16] - rd_b[23:16] : rd_b[23:16] - rd_a[23:16];

	always_ff @(posedge clk) begin
		if (v_s1_q) begin
			sq_r_s2 <= 16'(ad_r) * 16'(ad_r);
			sq_g_s2 <= 16'(ad_g) * 16'(ad_g);
			sq_b_s2 <= 16'(ad_b) * 16'(ad_b);
			use_s2  <= !a_masked_q || rd_a[24];
		end
	end

	// Stage 3: accumulate, then saturate into the output register.
	always_ff @(posedge clk) begin
		if (comp_xfer) begin
			acc_q <= '0;
		end else if (v_s2_q && use_s2) begin
			acc_q <= acc_q + mpse_pkg::ACC_W'(sq_r_s2) + mpse_pkg::ACC_W'(sq_g_s2)
				+ mpse_pkg::ACC_W'(sq_b_s2);
		end
		if (finish) begin
			energy_q <= (acc_q > mpse_pkg::ENERGY_CEIL) ?
				mpse_pkg::ENERGY_CEIL[mpse_pkg::ENERGY_W-1:0] : acc_q[mpse_pkg::ENERGY_W-1:0];
		end
	end

	assign out_valid = out_valid_q;
	assign energy    = energy_q;

`include "masked_patch_ssd_energy_core_assert.svh"

	// Pixel reads stay inside the clamped patch.
	`MPSE_ASSERT_SAME(a_issue_in_row, issue, x_q < w_q && y_q < h_q)
	// Accumulation only happens while a walk or its drain is under way.
	`MPSE_ASSERT_SAME(a_acc_busy, v_s2_q,
		state_q == mpse_pkg::ST_WALK || state_q == mpse_pkg::ST_DRAIN)
	// A compute transfer starts the clamp sequence at its first step.
	`MPSE_ASSERT_NEXT(a_comp_start, comp_xfer,
		state_q == mpse_pkg::ST_CLAMP && step_q == mpse_pkg::CLAMP_NEG_A)
	// A result appears only at the end of a compute.
	`MPSE_ASSERT_SAME(a_out_from_finish, $rose(out_valid_q),
		$past(state_q) == mpse_pkg::ST_FINISH)

endmodule

[test/tb_masked_patch_ssd_energy_core.sv]
`timescale 1ns / 100ps

module tb_masked_patch_ssd_energy_core;

	// The image store is addressed as row * IMG_DIM + column, whatever the configured image size.
	localparam int IMG_DIM = 256;
	localparam int IMG_PIXELS = IMG_DIM * IMG_DIM;
	localparam longint ENERGY_CAP = (longint'(1) << mpse_pkg::ENERGY_W) - 1;

	// A load gives no result, so SETTLE_CYCLES after the last
	// energy transfer the block is surely idle again.
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES = 40;
	localparam int HOLD_CYCLES = 600;
	localparam int CYCLE_LIMIT = 2000000;
	localparam int RANDOM_PHASES = 12;
	localparam int PHASE_ITEMS = 16;
	// Random phases keep coming until about this many input transfers have been made.
	localparam int ITEM_TARGET = 580;

	// One input transfer. Fields that the action does not use still carry random junk.
	typedef struct {
		logic act;
		logic [7:0] col;
		logic [7:0] row;
		logic [7:0] red;
		logic [7:0] grn;
		logic [7:0] blu;
		logic kn;
		logic signed [8:0] bl;
		logic signed [8:0] bt;
	} pixel_req_t;

	// Mirror of the block: its registers, the image and mask it holds, and the energies
	// that accepted compute transfers still owe.
	class energy_scoreboard;
		int a_left = 0;
		int a_top = 0;
		int patch_w = 8;
		int patch_h = 8;
		int img_w = 256;
		int img_h = 256;
		bit masked = 1'b0;
		logic [7:0] red_mem [0:IMG_PIXELS-1];
		logic [7:0] grn_mem [0:IMG_PIXELS-1];
		logic [7:0] blu_mem [0:IMG_PIXELS-1];
		bit known_mem [0:IMG_PIXELS-1];
		bit loaded [0:IMG_PIXELS-1];
		logic [mpse_pkg::ENERGY_W-1:0] energy_due [$];
		int mismatches = 0;

		task report(string msg);
			$display("mismatch: %s", msg);
			mismatches++;
		endtask

		function void set_reg(logic [2:0] idx, logic [8:0] val);
			case (idx)
				mpse_pkg::CFG_A_LEFT: a_left = int'($signed(val));
				mpse_pkg::CFG_A_TOP: a_top = int'($signed(val));
				mpse_pkg::CFG_PATCH_WIDTH: patch_w = int'(val);
				mpse_pkg::CFG_PATCH_HEIGHT: patch_h = int'(val);
				mpse_pkg::CFG_IMAGE_WIDTH: img_w = int'(val);
				mpse_pkg::CFG_IMAGE_HEIGHT: img_h = int'(val);
				mpse_pkg::CFG_A_MASKED: masked = val[0];
				default: ;
			endcase
		endfunction

		// Pull both corners onto the image along one axis. A negative corner pushes both
		// corners forward and eats into the span; a far edge past the limit cuts the span.
		function void clamp_pair(inout int pa, inout int pb, inout int n, input int lim);
			if (pa < 0) begin
				n = n + pa;
				pb = pb - pa;
				pa = 0;
			end
			if (pb < 0) begin
				n = n + pb;
				pa = pa - pb;
				pb = 0;
			end
			if (pa + n > lim) n = lim - pa;
			if (pb + n > lim) n = lim - pb;
		endfunction

		// Clamped corners and size of both patches; returns zero for an empty region.
		function bit patch_bounds(int bl_in, int bt_in, output int al, output int at,
				output int bl, output int bt, output int w, output int h);
			int lim_w;
			int lim_h;
			al = a_left;
			at = a_top;
			bl = bl_in;
			bt = bt_in;
			w = patch_w;
			h = patch_h;
			lim_w = (img_w > IMG_DIM) ? IMG_DIM : img_w;
			lim_h = (img_h > IMG_DIM) ? IMG_DIM : img_h;
			clamp_pair(al, bl, w, lim_w);
			clamp_pair(at, bt, h, lim_h);
			return (w > 0 && h > 0);
		endfunction

		function logic [mpse_pkg::ENERGY_W-1:0] predict_energy(int bl_in, int bt_in);
			int al, at, bl, bt, w, h, xx, yy, ai, bi, dr, dg, db;
			longint sum;
			sum = 0;
			if (!patch_bounds(bl_in, bt_in, al, at, bl, bt, w, h)) return '0;
			for (yy = 0; yy < h; yy++) begin
				for (xx = 0; xx < w; xx++) begin
					ai = (at + yy) * IMG_DIM + al + xx;
					bi = (bt + yy) * IMG_DIM + bl + xx;
					if (!masked || known_mem[ai]) begin
						dr = int'(red_mem[ai]) - int'(red_mem[bi]);
						dg = int'(grn_mem[ai]) - int'(grn_mem[bi]);
						db = int'(blu_mem[ai]) - int'(blu_mem[bi]);
						sum += longint'(dr * dr + dg * dg + db * db);
					end
				end
			end
			if (sum > ENERGY_CAP) sum = ENERGY_CAP;
			return sum[mpse_pkg::ENERGY_W-1:0];
		endfunction

		function void note_transfer(pixel_req_t t);
			int idx;
			if (t.act == mpse_pkg::ACT_LOAD) begin
				idx = int'(t.row) * IMG_DIM + int'(t.col);
				red_mem[idx] = t.red;
				grn_mem[idx] = t.grn;
				blu_mem[idx] = t.blu;
				known_mem[idx] = t.kn;
				loaded[idx] = 1'b1;
			end else begin
				energy_due = {energy_due, predict_energy(int'(t.bl), int'(t.bt))};
			end
		endfunction

		task check_energy(logic [mpse_pkg::ENERGY_W-1:0] got);
			logic [mpse_pkg::ENERGY_W-1:0] want;
			if (energy_due.size() == 0) begin
				report($sformatf("energy %0d arrived with no compute outstanding", got));
			end else begin
				want = energy_due.pop_front();
				if (got !== want) report($sformatf("energy %0d, expected %0d", got, want));
			end
		endtask
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic action;
	logic [7:0] pix_x;
	logic [7:0] pix_y;
	logic [7:0] red;
	logic [7:0] green;
	logic [7:0] blue;
	logic known;
	logic signed [8:0] b_left;
	logic signed [8:0] b_top;
	logic out_valid;
	logic out_stall;
	logic [mpse_pkg::ENERGY_W-1:0] energy;
	logic cfg_we;
	logic [2:0] cfg_idx;
	logic [8:0] cfg_data;

	energy_scoreboard sb = new;

	// Set by the stimulus: quiet turns off all idling on both sides, and hold_req asks the
	// receiver for one long hold-off.
	bit quiet = 1'b0;
	bit hold_req = 1'b0;
	int unsigned cycle_count = 0;
	int items_sent = 0;

	masked_patch_ssd_energy_core DUT (.*);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	// A run that outlives the limit has lost a transfer or hung the block.
	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("tb_masked_patch_ssd_energy_core: FAIL");
		$finish;
	end

	// Receiver side. out_stall changes at the falling edge only. On request it holds off for
	// a long stretch so that a finished energy parks in the output register, the next compute
	// parks behind it, and the block has to stall its input while the sender keeps offering.
	initial begin
		int hold_count;
		out_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_stall <= 1'b1;
				for (hold_count = 0; hold_count < HOLD_CYCLES; hold_count++) @(negedge clk);
				hold_req = 1'b0;
			end else begin
				out_stall <= !quiet && ($urandom_range(99) < 22);
			end
		end
	end

	// Every energy transfer is checked against the oldest outstanding prediction. Values are
	// taken at the rising edge, before the block updates anything for the next cycle.
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_energy(energy);
	end

	function automatic pixel_req_t junk_item();
		pixel_req_t t;
		t.act = mpse_pkg::ACT_LOAD;
		t.col = 8'($urandom);
		t.row = 8'($urandom);
		t.red = 8'($urandom);
		t.grn = 8'($urandom);
		t.blu = 8'($urandom);
		t.kn = 1'($urandom);
		t.bl = 9'($urandom);
		t.bt = 9'($urandom);
		return t;
	endfunction

	function automatic int sat9(int v);
		if (v > 255) return 255;
		if (v < -256) return -256;
		return v;
	endfunction

	// Image size for a random phase: mostly small images that are cheap to fill, some full
	// size, some single-pixel, and some past the maximum that the block must saturate.
	function automatic int pick_extent();
		int r;
		r = $urandom_range(99);
		if (r < 25) return IMG_DIM;
		if (r < 32) return 1;
		if (r < 38) return $urandom_range(511, IMG_DIM + 1);
		return $urandom_range(10, 2);
	endfunction

	// Patch size: small on a full-size image so that each compute stays short; on a small
	// image it may run past the edge or be as large as IMG_DIM.
	function automatic int pick_span(int lim);
		int r;
		r = $urandom_range(99);
		if (r < 5) return 0;
		if (lim > 24) return $urandom_range(4, 1);
		if (r < 12) return IMG_DIM;
		return $urandom_range(lim + 2, 1);
	endfunction

	function automatic int pick_corner(int lim);
		int r;
		r = $urandom_range(99);
		if (r < 6) return 255;
		if (r < 12) return -256;
		if (r < 20) return int'($urandom_range(511)) - 256;
		return int'($urandom_range(lim + 1)) - 2;
	endfunction

	// Offer one transfer and wait until it is accepted. All input changes happen at the
	// falling edge; the handshake is judged at the rising edge. Idle cycles come first, so a
	// payload never changes while it is being offered.
	task automatic send_item(pixel_req_t t);
		while (!quiet && $urandom_range(99) < 22) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		action <= t.act;
		pix_x <= t.col;
		pix_y <= t.row;
		red <= t.red;
		green <= t.grn;
		blue <= t.blu;
		known <= t.kn;
		b_left <= t.bl;
		b_top <= t.bt;
		do @(posedge clk); while (in_stall);
		sb.note_transfer(t);
		items_sent++;
	endtask

	// Ask for one energy. The image store holds garbage until written, so any pixel of either
	// clamped patch that has never been loaded gets a random load first.
	task automatic request_energy(int bl, int bt);
		int al, at, cbl, cbt, w, h, xx, yy, side, idx;
		pixel_req_t t;
		if (sb.patch_bounds(bl, bt, al, at, cbl, cbt, w, h)) begin
			for (yy = 0; yy < h; yy++) begin
				for (xx = 0; xx < w; xx++) begin
					for (side = 0; side < 2; side++) begin
						idx = side ? (cbt + yy) * IMG_DIM + cbl + xx
							: (at + yy) * IMG_DIM + al + xx;
						if (!sb.loaded[idx]) begin
							t = junk_item();
							t.act = mpse_pkg::ACT_LOAD;
							t.col = 8'(idx % IMG_DIM);
							t.row = 8'(idx / IMG_DIM);
							send_item(t);
						end
					end
				end
			end
		end
		t = junk_item();
		t.act = mpse_pkg::ACT_COMPUTE;
		t.bl = bl[8:0];
		t.bt = bt[8:0];
		send_item(t);
	endtask

	// Drop valid and wait until every owed energy has come back, plus time for a trailing load.
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.energy_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [8:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_idx <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		sb.set_reg(idx, val);
	endtask

	// Registers are only rewritten while the block is idle, and all of them every time.
	task automatic configure(int al, int at, int pw, int ph, int iw, int ih, bit msk);
		wait_idle();
		write_reg(mpse_pkg::CFG_A_LEFT, al[8:0]);
		write_reg(mpse_pkg::CFG_A_TOP, at[8:0]);
		write_reg(mpse_pkg::CFG_PATCH_WIDTH, pw[8:0]);
		write_reg(mpse_pkg::CFG_PATCH_HEIGHT, ph[8:0]);
		write_reg(mpse_pkg::CFG_IMAGE_WIDTH, iw[8:0]);
		write_reg(mpse_pkg::CFG_IMAGE_HEIGHT, ih[8:0]);
		write_reg(mpse_pkg::CFG_A_MASKED, {8'd0, msk});
	endtask

	// One random setting followed by a mix of loads inside the image and computes. Most
	// candidate corners sit near patch A so that the clamped patches overlap real data;
	// the rest roam over the image edges and over the whole signed range.
	task automatic random_phase(int n_items, bit hold);
		int iw_sel, ih_sel, iw_eff, ih_eff, al, at, bl, bt, k, r;
		pixel_req_t t;
		iw_sel = pick_extent();
		ih_sel = pick_extent();
		iw_eff = (iw_sel > IMG_DIM) ? IMG_DIM : iw_sel;
		ih_eff = (ih_sel > IMG_DIM) ? IMG_DIM : ih_sel;
		al = pick_corner(iw_eff);
		at = pick_corner(ih_eff);
		configure(al, at, pick_span(iw_eff), pick_span(ih_eff), iw_sel, ih_sel,
			1'($urandom_range(1)));
		if (hold) hold_req = 1'b1;
		for (k = 0; k < n_items; k++) begin
			if ($urandom_range(99) < 55) begin
				t = junk_item();
				t.act = mpse_pkg::ACT_LOAD;
				t.col = 8'($urandom_range(iw_eff - 1));
				t.row = 8'($urandom_range(ih_eff - 1));
				send_item(t);
			end else begin
				r = $urandom_range(99);
				if (r < 65) begin
					bl = sat9(al + int'($urandom_range(10)) - 5);
					bt = sat9(at + int'($urandom_range(10)) - 5);
				end else if (r < 90) begin
					bl = int'($urandom_range(iw_eff + 1)) - 2;
					bt = int'($urandom_range(ih_eff + 1)) - 2;
				end else begin
					bl = int'($urandom_range(511)) - 256;
					bt = int'($urandom_range(511)) - 256;
				end
				request_energy(bl, bt);
			end
		end
	endtask

	initial begin
		int k;
		pixel_req_t t;
		arst_n = 1'b0;
		in_valid = 1'b0;
		action = mpse_pkg::ACT_LOAD;
		pix_x = '0;
		pix_y = '0;
		red = '0;
		green = '0;
		blue = '0;
		known = 1'b0;
		b_left = '0;
		b_top = '0;
		cfg_we = 1'b0;
		cfg_idx = mpse_pkg::CFG_A_LEFT;
		cfg_data = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset values of the registers: an 8 by 8 patch at the origin of a full-size image.
		// A candidate far to the left leaves nothing after clamping; the second one is real.
		request_energy(-256, 0);
		request_energy(0, 4);

		// A 4 by 4 image filled with extreme channel values and a mixed mask.
		configure(0, 0, 4, 4, 4, 4, 1'b0);
		for (k = 0; k < 16; k++) begin
			t = junk_item();
			t.act = mpse_pkg::ACT_LOAD;
			t.col = 8'(k % 4);
			t.row = 8'(k / 4);
			t.red = (k & 1) ? 8'hFF : 8'h00;
			t.grn = (k & 2) ? 8'hFF : 8'h00;
			t.blu = (k & 4) ? 8'hFF : ((k & 8) ? 8'h80 : 8'h00);
			t.kn = (k % 3 != 0);
			send_item(t);
		end
		// Identical patches, a candidate past the far edge, a negative candidate corner that
		// drags patch A along, and candidates at both ends of the signed range.
		request_energy(0, 0);
		request_energy(1, 1);
		request_energy(-1, -2);
		request_energy(-256, -256);
		request_energy(255, 255);
		request_energy(0, 3);

		// Masking on, with a negative corner for patch A itself.
		configure(-1, -2, 4, 4, 4, 4, 1'b1);
		request_energy(0, 0);
		request_energy(1, 1);
		request_energy(2, -1);

		// A zero image width leaves no region at all.
		configure(-1, -2, 4, 4, 0, 4, 1'b1);
		request_energy(0, 0);

		// Widest patch over the last row, with an image width beyond the maximum. A candidate
		// one column to the right shares the row and loses one column at the far edge.
		configure(0, 255, 256, 1, 300, 256, 1'b0);
		request_energy(1, 255);
		request_energy(0, 255);
		request_energy(-256, -256);

		// Tallest patch near the bottom of the last column, image height beyond the maximum,
		// masked; the bottom edge cuts the shared height down to a few rows.
		configure(255, 250, 1, 256, 256, 300, 1'b1);
		request_energy(255, 252);
		request_energy(255, -256);

		// Zero-size patch on a single-pixel image, patch A at the far corners.
		configure(-256, 255, 0, 0, 1, 1, 1'b0);
		request_energy(0, 0);

		// Random settings. The first phase carries the long receiver hold-off, and the next
		// two back-to-back phases run with no idling on either side.
		for (k = 0; k < RANDOM_PHASES && (k < 3 || items_sent < ITEM_TARGET); k++) begin
			quiet = (k == 1 || k == 2);
			random_phase(PHASE_ITEMS, k == 0);
		end
		quiet = 1'b0;

		wait_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("tb_masked_patch_ssd_energy_core: PASS");
		end else begin
			$display("tb_masked_patch_ssd_energy_core: FAIL");
		end
		$finish;
	end

endmodule
